[rtl/msh_pkg.sv]
// Package for the magnetometer scale and heading block.
// Shared types, constants and constant tables; no dependencies.
`default_nettype none

package msh_pkg;

  localparam int AXIS_W       = 16;
  localparam int FIELD_W      = 21;
  localparam int HEAD_W       = 16;
  localparam int GAIN_W       = 3;
  localparam int DIV_W        = 12;   // width of 2 * LSB-per-gauss
  localparam int ZACC_W       = 26;   // angle accumulator, 1/32768 degree
  localparam int CORDIC_W     = 33;   // CORDIC x/y datapath
  localparam int ATAN_LEN     = 24;
  localparam int QUEUE_DEPTH  = 4;

  localparam int CORDIC_STEPS_DEF        = 16;
  localparam int FIELD_FRACTION_BITS_DEF = 12;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 3'd1;

  localparam logic signed [ZACC_W-1:0] DEG180 = 26'sd5898240;
  localparam logic signed [ZACC_W-1:0] DEG360 = 26'sd11796480;
  localparam logic [17:0]              HEAD_WRAP = 18'd46080;
  localparam logic signed [ZACC_W-1:0] ROUND_HALF = 26'sd128;

  // One queued sample with its classification
  typedef struct packed {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
    logic [GAIN_W-1:0]        gain;
    logic                     x_neg;
    logic                     zero;
  } msh_item_t;

  // Handshake between two internal parts
  typedef struct packed {
    logic valid;
    logic stall;
  } msh_hs_t;

  // 2 * LSB per gauss for each gain code
  function automatic logic [DIV_W-1:0] div_of(input logic [GAIN_W-1:0] g);
    logic [DIV_W-1:0] d;
    begin
      case (g)
        3'd0: d = 12'd2740;
        3'd1: d = 12'd2180;
        3'd2: d = 12'd1640;
        3'd3: d = 12'd1320;
        3'd4: d = 12'd880;
        3'd5: d = 12'd780;
        3'd6: d = 12'd660;
        default: d = 12'd460;
      endcase
      return d;
    end
  endfunction

  // atan(2^-i) in 1/32768 degree
  function automatic int atan_of(input int i);
    int a;
    begin
      case (i)
        0: a = 1474560;
        1: a = 870484;
        2: a = 459940;
        3: a = 233473;
        4: a = 117189;
        5: a = 58652;
        6: a = 29333;
        7: a = 14667;
        8: a = 7334;
        9: a = 3667;
        10: a = 1833;
        11: a = 917;
        12: a = 458;
        13: a = 229;
        14: a = 115;
        15: a = 57;
        16: a = 29;
        17: a = 14;
        18: a = 7;
        19: a = 4;
        20: a = 2;
        21: a = 1;
        default: a = 0;
      endcase
      return a;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/msh_front.sv]
// Front end: accepts samples and classifies them for the back end.
// Depends on msh_pkg.
`default_nettype none

module msh_front import msh_pkg::*; (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire signed [AXIS_W-1:0] axis_x_i,
  input  wire signed [AXIS_W-1:0] axis_z_i,
  input  wire signed [AXIS_W-1:0] axis_y_i,
  input  wire [GAIN_W-1:0]        gain_i,
  output msh_hs_t                 push_o,
  input  wire                     full_i,
  output msh_item_t               item_o
);

  logic      valid_q, valid_d;
  logic      take;
  msh_item_t item_q;

  assign in_stall_o = valid_q & full_i;
  assign take       = in_valid_i & ~in_stall_o;

  // hold a sample until the queue has room
  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (valid_q && !full_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // classify: quadrant fold and the all-zero case
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.x     <= axis_x_i;
      item_q.y     <= axis_y_i;
      item_q.z     <= axis_z_i;
      item_q.gain  <= gain_i;
      item_q.x_neg <= axis_x_i[AXIS_W-1];
      item_q.zero  <= (axis_x_i == '0) && (axis_y_i == '0);
    end
  end

  assign push_o.valid = valid_q;
  assign push_o.stall = full_i;
  assign item_o       = item_q;

endmodule

`default_nettype wire

[rtl/msh_queue.sv]
// Small FIFO between the front and back ends.
// Depends on msh_pkg.
`default_nettype none

module msh_queue import msh_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  msh_hs_t   push_i,
  input  msh_item_t item_i,
  output logic      full_o,
  output logic      empty_o,
  input  wire       pop_i,
  output msh_item_t item_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  msh_item_t       mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            push, pop;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign push    = push_i.valid & ~push_i.stall;
  assign pop     = pop_i & ~empty_o;
  assign item_o  = mem_q[rd_q];

  // pointer and count update
  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

[rtl/msh_back.sv]
// Back end: field scaling and pipelined CORDIC heading, one stage per step.
// Depends on msh_pkg.
`default_nettype none

module msh_back import msh_pkg::*; #(
  parameter int CORDIC_STEPS        = CORDIC_STEPS_DEF,
  parameter int FIELD_FRACTION_BITS = FIELD_FRACTION_BITS_DEF
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       empty_i,
  input  msh_item_t                 item_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output logic signed [FIELD_W-1:0] field_x_o,
  output logic signed [FIELD_W-1:0] field_y_o,
  output logic signed [FIELD_W-1:0] field_z_o,
  output logic [HEAD_W-1:0]         heading_o
);

  // numerator width, reciprocal shift and reciprocal width
  localparam int NW = FIELD_FRACTION_BITS + 18;
  localparam int K  = NW;
  localparam int RW = NW - 8;
  localparam int QW = RW + 1;

  localparam logic [RW-1:0] RECIP [8] = '{
    RW'((64'd1 << K) / 64'd2740), RW'((64'd1 << K) / 64'd2180),
    RW'((64'd1 << K) / 64'd1640), RW'((64'd1 << K) / 64'd1320),
    RW'((64'd1 << K) / 64'd880),  RW'((64'd1 << K) / 64'd780),
    RW'((64'd1 << K) / 64'd660),  RW'((64'd1 << K) / 64'd460)
  };

  localparam logic [QW-1:0] QMAX_POS = QW'(1048575);
  localparam logic [QW-1:0] QMAX_NEG = QW'(1048576);

  typedef struct packed {
    logic signed [CORDIC_W-1:0]   cx;
    logic signed [CORDIC_W-1:0]   cy;
    logic signed [ZACC_W-1:0]     cz;
    logic                         zero;
    logic [DIV_W-1:0]             d;
    logic [2:0][NW-1:0]           n;
    logic [2:0][QW-1:0]           q;
    logic [2:0]                   neg;
    logic [2:0][FIELD_W-1:0]      f;
  } stage_t;

  logic                  en;
  logic [CORDIC_STEPS:0] v_q;
  stage_t                s_q [CORDIC_STEPS+1];
  stage_t                s_d [CORDIC_STEPS+1];

  logic                       out_valid_q;
  logic signed [FIELD_W-1:0]  fx_q, fy_q, fz_q;
  logic [HEAD_W-1:0]          head_q, head_d;

  // whole pipe advances unless a finished result is held
  assign en    = ~(out_valid_q & out_stall_i);
  assign pop_o = en;

  // preparation: magnitudes, reciprocal products, CORDIC start vector
  always_comb begin
    logic signed [AXIS_W-1:0]   raw [3];
    logic [AXIS_W-1:0]          mag;
    logic [NW-1:0]              num;
    logic [NW+RW-1:0]           prod;
    logic signed [CORDIC_W-1:0] ex, ey;
    raw[0] = item_i.x;
    raw[1] = item_i.y;
    raw[2] = item_i.z;
    s_d[0] = '0;
    s_d[0].d = div_of(item_i.gain);
    for (int a = 0; a < 3; a++) begin
      mag  = raw[a][AXIS_W-1] ? AXIS_W'(-raw[a]) : AXIS_W'(raw[a]);
      num  = (NW'(mag) << (FIELD_FRACTION_BITS + 1)) + NW'(s_d[0].d >> 1);
      prod = (NW+RW)'(num) * (NW+RW)'(RECIP[item_i.gain]);
      s_d[0].n[a]   = num;
      s_d[0].q[a]   = QW'(prod[NW+RW-1:K]);
      s_d[0].neg[a] = raw[a][AXIS_W-1];
    end
    ex = CORDIC_W'(item_i.x);
    ey = CORDIC_W'(item_i.y);
    if (item_i.x_neg) begin
      ex = -ex;
      ey = -ey;
    end
    s_d[0].cx   = ex <<< 14;
    s_d[0].cy   = ey <<< 14;
    s_d[0].cz   = item_i.x_neg ? DEG180 : '0;
    s_d[0].zero = item_i.zero;
  end

  // CORDIC iterations, with the field correction and saturation riding along
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZACC_W-1:0] ATAN = ZACC_W'(atan_of(i));
    always_comb begin
      logic signed [CORDIC_W-1:0] xs, ys;
      logic [QW+DIV_W-1:0]        prod;
      s_d[i+1] = s_q[i];
      xs = s_q[i].cx >>> i;
      ys = s_q[i].cy >>> i;
      if (s_q[i].cy < 0) begin
        s_d[i+1].cx = s_q[i].cx - ys;
        s_d[i+1].cy = s_q[i].cy + xs;
        s_d[i+1].cz = s_q[i].cz - ATAN;
      end else begin
        s_d[i+1].cx = s_q[i].cx + ys;
        s_d[i+1].cy = s_q[i].cy - xs;
        s_d[i+1].cz = s_q[i].cz + ATAN;
      end
      for (int a = 0; a < 3; a++) begin
        prod = (QW+DIV_W)'(s_q[i].q[a]) * (QW+DIV_W)'(s_q[i].d);
        if (i == 0) begin
          // quotient estimate is low by at most one
          if (prod + (QW+DIV_W)'(s_q[i].d) <= (QW+DIV_W)'(s_q[i].n[a])) begin
            s_d[i+1].q[a] = s_q[i].q[a] + 1'b1;
          end
        end else if (i == 1) begin
          // sign and 21-bit saturation
          if (s_q[i].neg[a]) begin
            s_d[i+1].f[a] = (s_q[i].q[a] > QMAX_NEG) ? FIELD_W'(QMAX_NEG)
                                                     : FIELD_W'(-s_q[i].q[a]);
          end else begin
            s_d[i+1].f[a] = (s_q[i].q[a] > QMAX_POS) ? FIELD_W'(QMAX_POS)
                                                     : FIELD_W'(s_q[i].q[a]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[CORDIC_STEPS-1:0], ~empty_i};
      out_valid_q <= v_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= CORDIC_STEPS; k++) begin
        s_q[k] <= s_d[k];
      end
    end
  end

  // heading: fold into [0,360), round to 1/128 degree, wrap
  always_comb begin
    logic signed [ZACC_W-1:0] zt;
    logic [17:0]              r;
    zt = s_q[CORDIC_STEPS].cz;
    if (zt < 0) begin
      zt = zt + DEG360;
    end
    zt = zt + ROUND_HALF;
    r  = 18'(zt >>> 8);
    if (r >= HEAD_WRAP) begin
      r = r - HEAD_WRAP;
    end
    head_d = s_q[CORDIC_STEPS].zero ? '0 : HEAD_W'(r);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_q   <= s_q[CORDIC_STEPS].f[0];
      fy_q   <= s_q[CORDIC_STEPS].f[1];
      fz_q   <= s_q[CORDIC_STEPS].f[2];
      head_q <= head_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign field_x_o   = fx_q;
  assign field_y_o   = fy_q;
  assign field_z_o   = fz_q;
  assign heading_o   = head_q;

  // heading stays below a full turn
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ({2'b00, head_q} < HEAD_WRAP))
    else $error("heading out of range");

  // corrected quotient is not above the exact one
  a_quot_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (64'(s_q[1].q[0]) * 64'(s_q[1].d) <= 64'(s_q[1].n[0])))
    else $error("field quotient too large");

  // corrected quotient is not below the exact one
  a_quot_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (64'(s_q[1].q[0]) * 64'(s_q[1].d) + 64'(s_q[1].d)
                > 64'(s_q[1].n[0])))
    else $error("field quotient too small");

endmodule

`default_nettype wire

[rtl/magnetometer_scale_and_heading_core.sv]
// Top level: gain register, front end, queue and back end.
// Depends on msh_pkg, msh_front, msh_queue, msh_back.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid_i, in_stall_o, axis_x/z/y_i      | in
//  output  | out_valid_o, out_stall_i, field_x/y/z_o,  | out
//          | heading_o                                |
//  config  | cfg_we_i, cfg_data_i (gain code)         | in
//
// One sample per cycle sustained while out_stall_i is low. With the queue empty,
// a sample moves from the front register, loaded at the accepting edge, through
// queue write, preparation stage, one stage per CORDIC step and output register,
// where out_valid_o rises. Reset clears control state and sets the gain code to 1.
// A stalled output freezes the back end; the four-entry queue and the front
// register keep taking samples until they fill.
`default_nettype none

module magnetometer_scale_and_heading_core import msh_pkg::*; #(
  parameter int CORDIC_STEPS        = CORDIC_STEPS_DEF,
  parameter int FIELD_FRACTION_BITS = FIELD_FRACTION_BITS_DEF
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire [GAIN_W-1:0]          cfg_data_i,
  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  wire signed [AXIS_W-1:0]   axis_x_i,
  input  wire signed [AXIS_W-1:0]   axis_z_i,
  input  wire signed [AXIS_W-1:0]   axis_y_i,
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output logic signed [FIELD_W-1:0] field_x_o,
  output logic signed [FIELD_W-1:0] field_y_o,
  output logic signed [FIELD_W-1:0] field_z_o,
  output logic [HEAD_W-1:0]         heading_o
);

  logic [GAIN_W-1:0] gain_q;
  msh_hs_t           push;
  msh_item_t         front_item, head_item;
  logic              full, empty, pop;

  // gain code register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_we_i) begin
      gain_q <= cfg_data_i;
    end
  end

  msh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .axis_x_i   (axis_x_i),
    .axis_z_i   (axis_z_i),
    .axis_y_i   (axis_y_i),
    .gain_i     (gain_q),
    .push_o     (push),
    .full_i     (full),
    .item_o     (front_item)
  );

  msh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .item_o  (head_item)
  );

  msh_back #(
    .CORDIC_STEPS        (CORDIC_STEPS),
    .FIELD_FRACTION_BITS (FIELD_FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .field_x_o   (field_x_o),
    .field_y_o   (field_y_o),
    .field_z_o   (field_z_o),
    .heading_o   (heading_o)
  );

endmodule

`default_nettype wire

[test/magnetometer_scale_and_heading_core_test.sv]
// Testbench for magnetometer_scale_and_heading_core: field scaling and CORDIC heading.
// Needs msh_pkg and the core RTL; checks every output transfer against a local predictor.
`timescale 1ns / 1ps

module magnetometer_scale_and_heading_core_test;
  import msh_pkg::*;

  localparam int STEPS     = 16;
  localparam int FRAC_BITS = 12;
  localparam int LATENCY   = STEPS + 12;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [FIELD_W-1:0] fx;
    logic signed [FIELD_W-1:0] fy;
    logic signed [FIELD_W-1:0] fz;
    logic [HEAD_W-1:0]         hdg;
  } sample_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [GAIN_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [AXIS_W-1:0] axis_x_i = '0, axis_z_i = '0, axis_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [FIELD_W-1:0] field_x_o, field_y_o, field_z_o;
  logic [HEAD_W-1:0] heading_o;

  sample_result_t expected_q[$];
  logic [GAIN_W-1:0] gain_sel = GAIN_RESET;
  int errors = 0;
  bit idle_on = 1'b1;
  longint cycles = 0;

  magnetometer_scale_and_heading_core #(
    .CORDIC_STEPS(STEPS), .FIELD_FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_stall_o,
    .axis_x_i, .axis_z_i, .axis_y_i, .out_valid_o, .out_stall_i,
    .field_x_o, .field_y_o, .field_z_o, .heading_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Divide by LSB per gauss, round halves away from zero, saturate
  function automatic logic signed [FIELD_W-1:0] scaled_field(input logic signed [AXIS_W-1:0] raw,
                                                            input logic [GAIN_W-1:0] g);
    longint lsb, mag, q;
    case (g)
      3'd0: lsb = 1370;
      3'd1: lsb = 1090;
      3'd2: lsb = 820;
      3'd3: lsb = 660;
      3'd4: lsb = 440;
      3'd5: lsb = 390;
      3'd6: lsb = 330;
      default: lsb = 230;
    endcase
    mag = (raw < 0) ? -longint'(raw) : longint'(raw);
    mag = mag << FRAC_BITS;
    q = (mag * 2 + lsb) / (2 * lsb);
    if (raw < 0) q = (q > 1048576) ? -1048576 : -q;
    else if (q > 1048575) q = 1048575;
    return q[FIELD_W-1:0];
  endfunction

  // Floor division by 2^s
  function automatic longint floor_div(input longint v, input int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  // Vectoring CORDIC heading in 1/128 degree
  function automatic logic [HEAD_W-1:0] compass_heading(input longint x, input longint y);
    longint ang, xs, ys;
    longint atan_step[24] = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
                              7334, 3667, 1833, 917, 458, 229, 115, 57,
                              29, 14, 7, 4, 2, 1, 0, 0};
    ang = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 180 * 32768;
    end
    x = x * 16384;
    y = y * 16384;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = floor_div(x, i);
      ys = floor_div(y, i);
      if (y < 0) begin
        x = x - ys;
        y = y + xs;
        ang -= atan_step[i];
      end else begin
        x = x + ys;
        y = y - xs;
        ang += atan_step[i];
      end
    end
    if (ang < 0) ang += 360 * 32768;
    ang = (ang + 128) >>> 8;
    if (ang >= 46080) ang -= 46080;
    return ang[HEAD_W-1:0];
  endfunction

  task automatic idle_burst();
    repeat ($urandom_range(1, 7)) @(negedge clk_i);
  endtask

  // One input transfer; queues its expected result
  task automatic send_sample(input logic signed [AXIS_W-1:0] x, input logic signed [AXIS_W-1:0] z,
                             input logic signed [AXIS_W-1:0] y);
    sample_result_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      idle_burst();
    end
    in_valid_i <= 1'b1;
    axis_x_i <= x;
    axis_z_i <= z;
    axis_y_i <= y;
    r.fx = scaled_field(x, gain_sel);
    r.fy = scaled_field(y, gain_sel);
    r.fz = scaled_field(z, gain_sel);
    r.hdg = compass_heading(x, y);
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(r);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= g;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    gain_sel = g;
  endtask

  // Output stall generator
  initial begin
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        idle_burst();
      end
      out_stall_i <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    sample_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("%t: unexpected result heading %0d", $time, heading_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (field_x_o !== e.fx) begin
          $display("%t: field_x expected %0d actual %0d", $time, e.fx, field_x_o);
          errors++;
        end
        if (field_y_o !== e.fy) begin
          $display("%t: field_y expected %0d actual %0d", $time, e.fy, field_y_o);
          errors++;
        end
        if (field_z_o !== e.fz) begin
          $display("%t: field_z expected %0d actual %0d", $time, e.fz, field_z_o);
          errors++;
        end
        if (heading_o !== e.hdg) begin
          $display("%t: heading expected %0d actual %0d", $time, e.hdg, heading_o);
          errors++;
        end
      end
    end
  end

  // Extremes, zero vector, axes and quadrants at reset gain
  task automatic test_directed();
    send_sample(0, 0, 0);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(-16'sh8000, -16'sh8000, -16'sh8000);
    send_sample(16'sh7fff, 0, 0);
    send_sample(-16'sh8000, 0, 0);
    send_sample(0, 1, 16'sh7fff);
    send_sample(0, -1, -16'sh8000);
    send_sample(-1, 0, 0);
    send_sample(1, 0, -1);
    send_sample(-1, 5, -1);
    send_sample(1000, -545, 1000);
    send_sample(-1000, 545, 1000);
    send_sample(1000, 0, -1);
    send_sample(-5555, -32768, 16'sh5555);
    send_sample(16'sh5555, 32767, -16'sh2aab);
  endtask

  task automatic test_gain_extremes();
    for (int g = 7; g >= 0; g--) begin
      write_gain(g[GAIN_W-1:0]);
      send_sample(16'sh7fff, -16'sh8000, 545);
      send_sample(-16'sh8000, 16'sh7fff, -545);
      send_sample(115, -115, 0);
    end
  endtask

  task automatic test_random();
    logic [15:0] a, b, c;
    for (int ph = 0; ph < 6; ph++) begin
      write_gain(GAIN_W'($urandom_range(0, 7)));
      if (ph == 5) idle_on = 1'b0;
      for (int n = 0; n < 230; n++) begin
        a = 16'($urandom);
        b = 16'($urandom);
        c = 16'($urandom);
        if ($urandom_range(0, 7) == 0) a = 16'($urandom_range(0, 3) - 2);
        if ($urandom_range(0, 7) == 0) c = 16'($urandom_range(0, 3) - 2);
        send_sample(a, b, c);
      end
      if (ph == 2) drain();
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_gain_extremes();
    test_random();
    drain();
    if (errors == 0 && expected_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
